[hdl/tbis_pkg.sv]
// Shared constants, types and the beep pattern table of the interval scheduler.
package tbis_pkg;

   localparam int MAX_ENTRIES = 8;
   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMD_W  = 3;
   localparam int TIME_W = 32;
   localparam int DUR_W  = 31;
   localparam int TONE_W = 16;
   localparam int FIRE_W = 7;
   localparam int ACC_W  = 2;
   localparam int STEP_W = 2;
   localparam int OFF_W  = 13;

   localparam logic [TONE_W-1:0] TONE_RESET = 16'd800;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK      = 3'd0,
      CMD_SCHEDULE  = 3'd1,
      CMD_BEEP      = 3'd2,
      CMD_SUCCESS   = 3'd3,
      CMD_ERROR     = 3'd4,
      CMD_WARNING   = 3'd5,
      CMD_COUNTDOWN = 3'd6,
      CMD_CLEAR     = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_MOVE,
      ST_INSERT,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic scan_step;
      logic move;
      logic insert;
      logic load_rsp;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_tick;
      logic is_clear;
      logic scan_done;
      logic expired;
      logic ins_last;
      logic rsp_full;
   } stat_type;

   typedef struct packed {
      logic [OFF_W-1:0] start_off;
      logic [OFF_W-1:0] end_off;
      logic             sig_cb;
      logic             last;
   } pat_type;

   // Offsets of one entry of a fixed pattern. Single-entry commands get a
   // zero start offset and are always the last entry.
   function automatic pat_type pattern_entry(cmd_type cmd, logic [STEP_W-1:0] step);
      pat_type p;
      p.start_off = '0;
      p.end_off   = '0;
      p.sig_cb    = 1'b0;
      p.last      = 1'b1;
      case (cmd)
         CMD_SUCCESS: begin
            if (step == 2'd0) begin
               p.end_off = 13'd300;
               p.last    = 1'b0;
            end else begin
               p.start_off = 13'd600;
               p.end_off   = 13'd900;
            end
         end
         CMD_ERROR: begin
            if (step == 2'd0) begin
               p.end_off = 13'd1000;
               p.last    = 1'b0;
            end else begin
               p.start_off = 13'd1100;
               p.end_off   = 13'd1200;
            end
         end
         CMD_WARNING: begin
            if (step == 2'd0) begin
               p.end_off = 13'd400;
               p.last    = 1'b0;
            end else begin
               p.start_off = 13'd800;
               p.end_off   = 13'd1200;
            end
         end
         CMD_COUNTDOWN: begin
            case (step)
               2'd0: begin
                  p.end_off = 13'd1000;
                  p.last    = 1'b0;
               end
               2'd1: begin
                  p.start_off = 13'd2000;
                  p.end_off   = 13'd3000;
                  p.last      = 1'b0;
               end
               default: begin
                  p.start_off = 13'd4000;
                  p.end_off   = 13'd6000;
                  p.sig_cb    = 1'b1;
               end
            endcase
         end
         default: begin
            p.last = 1'b1;
         end
      endcase
      return p;
   endfunction

endpackage

[hdl/tbis_if.sv]
// Valid/ready channel interfaces for the scheduler's command and result items.
interface tbis_req_if;
   logic                            valid;
   logic                            ready;
   logic [tbis_pkg::CMD_W-1:0]      cmd;
   logic [tbis_pkg::TIME_W-1:0]     now;
   logic [tbis_pkg::TIME_W-1:0]     start_time;
   logic [tbis_pkg::TIME_W-1:0]     end_time;
   logic [tbis_pkg::DUR_W-1:0]      duration;
   logic                            has_callback;

   modport source(output valid, cmd, now, start_time, end_time, duration, has_callback,
                  input ready);
   modport sink(input valid, cmd, now, start_time, end_time, duration, has_callback,
                output ready);
endinterface

interface tbis_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            buzzer_on;
   logic                            changed;
   logic [tbis_pkg::TONE_W-1:0]     tone_out;
   logic [tbis_pkg::FIRE_W-1:0]     callbacks_fired;
   logic [tbis_pkg::ACC_W-1:0]      accepted;

   modport source(output valid, buzzer_on, changed, tone_out, callbacks_fired, accepted,
                  input ready);
   modport sink(input valid, buzzer_on, changed, tone_out, callbacks_fired, accepted,
                output ready);
endinterface

[hdl/tbis_ctrl.sv]
// Sequencing state machine of the interval scheduler.
module tbis_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               rsp_ready,
   input  tbis_pkg::stat_type stat,
   output tbis_pkg::ctrl_type ctrl
);

   tbis_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbis_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tbis_pkg::ST_IDLE: begin
            if (req_valid) state_in = tbis_pkg::ST_DISPATCH;
         end
         tbis_pkg::ST_DISPATCH: begin
            if (stat.is_tick) state_in = tbis_pkg::ST_SCAN;
            else if (stat.is_clear) state_in = tbis_pkg::ST_FINISH;
            else state_in = tbis_pkg::ST_INSERT;
         end
         tbis_pkg::ST_SCAN: begin
            if (stat.scan_done) state_in = tbis_pkg::ST_FINISH;
            else if (stat.expired) state_in = tbis_pkg::ST_MOVE;
         end
         tbis_pkg::ST_MOVE: begin
            state_in = tbis_pkg::ST_SCAN;
         end
         tbis_pkg::ST_INSERT: begin
            if (stat.ins_last) state_in = tbis_pkg::ST_FINISH;
         end
         tbis_pkg::ST_FINISH: begin
            if (!stat.rsp_full || rsp_ready) state_in = tbis_pkg::ST_IDLE;
         end
         default: begin
            state_in = tbis_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = 1'b0;
      ctrl           = '0;
      case (state_ff)
         tbis_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            ctrl.capture = req_valid;
         end
         tbis_pkg::ST_SCAN: begin
            ctrl.scan_step = !stat.scan_done && !stat.expired;
         end
         tbis_pkg::ST_MOVE: begin
            ctrl.move = 1'b1;
         end
         tbis_pkg::ST_INSERT: begin
            ctrl.insert = 1'b1;
         end
         tbis_pkg::ST_FINISH: begin
            ctrl.load_rsp = !stat.rsp_full || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[hdl/tbis_datapath.sv]
// Entry table, counters, tone register and result register of the scheduler.
module tbis_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  tbis_pkg::ctrl_type              ctrl,
   output tbis_pkg::stat_type              stat,
   input  logic [tbis_pkg::CMD_W-1:0]      req_cmd,
   input  logic [tbis_pkg::TIME_W-1:0]     req_now,
   input  logic [tbis_pkg::TIME_W-1:0]     req_start_time,
   input  logic [tbis_pkg::TIME_W-1:0]     req_end_time,
   input  logic [tbis_pkg::DUR_W-1:0]      req_duration,
   input  logic                            req_has_callback,
   input  logic                            csr_wr_en,
   input  logic [tbis_pkg::TONE_W-1:0]     csr_wr_data,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_buzzer_on,
   output logic                            rsp_changed,
   output logic [tbis_pkg::TONE_W-1:0]     rsp_tone_out,
   output logic [tbis_pkg::FIRE_W-1:0]     rsp_callbacks_fired,
   output logic [tbis_pkg::ACC_W-1:0]      rsp_accepted
);

   localparam int MAX_ENTRIES = tbis_pkg::MAX_ENTRIES;
   localparam int IDX_W  = tbis_pkg::IDX_W;
   localparam int CNT_W  = tbis_pkg::CNT_W;
   localparam int TIME_W = tbis_pkg::TIME_W;
   localparam int TONE_W = tbis_pkg::TONE_W;
   localparam int FIRE_W = tbis_pkg::FIRE_W;
   localparam int ACC_W  = tbis_pkg::ACC_W;
   localparam int STEP_W = tbis_pkg::STEP_W;

   // Entry table, read at one address per cycle.
   logic [TIME_W-1:0] start_ff [MAX_ENTRIES];
   logic [TIME_W-1:0] end_ff   [MAX_ENTRIES];
   logic              sig_ff   [MAX_ENTRIES];
   logic              fired_ff [MAX_ENTRIES];

   // Captured item.
   tbis_pkg::cmd_type                 cmd_ff;
   logic [TIME_W-1:0]                 now_ff, st_ff, en_ff;
   logic [tbis_pkg::DUR_W-1:0]        dur_ff;
   logic                              cb_ff;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              on_ff, on_in;
   logic [FIRE_W-1:0] fire_ff, fire_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              buzzer_ff, buzzer_in;
   logic [TONE_W-1:0] tone_ff, tone_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [CNT_W-1:0]  last_cnt;
   logic [IDX_W-1:0]  rd_addr;
   logic [TIME_W-1:0] rd_start, rd_end;
   logic              rd_sig, rd_fired;
   logic              active, fire_now, table_full, do_insert, new_buzzer;
   tbis_pkg::pat_type pat;
   logic [TIME_W-1:0] ins_start, ins_end, ins_end_off;
   logic              ins_sig, is_sched;

   assign last_cnt = count_ff - CNT_W'(1);
   assign rd_addr  = ctrl.move ? last_cnt[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign rd_start = start_ff[rd_addr];
   assign rd_end   = end_ff[rd_addr];
   assign rd_sig   = sig_ff[rd_addr];
   assign rd_fired = fired_ff[rd_addr];

   // An entry that survived the expiry check is active once its start is reached.
   assign active   = rd_start <= now_ff;
   assign fire_now = ctrl.scan_step && active && rd_sig && !rd_fired;

   assign table_full = count_ff >= CNT_W'(MAX_ENTRIES);
   assign do_insert  = ctrl.insert && !table_full;

   assign is_sched    = cmd_ff == tbis_pkg::CMD_SCHEDULE;
   assign pat         = tbis_pkg::pattern_entry(cmd_ff, step_ff);
   assign ins_end_off = (cmd_ff == tbis_pkg::CMD_BEEP) ? TIME_W'(dur_ff)
                                                       : TIME_W'(pat.end_off);
   assign ins_start   = is_sched ? st_ff : now_ff + TIME_W'(pat.start_off);
   assign ins_end     = is_sched ? en_ff : now_ff + ins_end_off;
   assign ins_sig     = is_sched ? cb_ff : (pat.sig_cb && cb_ff);

   assign stat.is_tick   = cmd_ff == tbis_pkg::CMD_TICK;
   assign stat.is_clear  = cmd_ff == tbis_pkg::CMD_CLEAR;
   assign stat.scan_done = idx_ff >= count_ff;
   assign stat.expired   = rd_end < now_ff;
   assign stat.ins_last  = pat.last;
   assign stat.rsp_full  = rsp_valid_ff;

   assign new_buzzer = stat.is_tick ? on_ff : (stat.is_clear ? 1'b0 : buzzer_ff);

   always_ff @(posedge clock) begin
      if (ctrl.move) begin
         start_ff[idx_ff[IDX_W-1:0]] <= rd_start;
         end_ff[idx_ff[IDX_W-1:0]]   <= rd_end;
         sig_ff[idx_ff[IDX_W-1:0]]   <= rd_sig;
         fired_ff[idx_ff[IDX_W-1:0]] <= rd_fired;
      end else if (do_insert) begin
         start_ff[count_ff[IDX_W-1:0]] <= ins_start;
         end_ff[count_ff[IDX_W-1:0]]   <= ins_end;
         sig_ff[count_ff[IDX_W-1:0]]   <= ins_sig;
         fired_ff[count_ff[IDX_W-1:0]] <= 1'b0;
      end else if (fire_now) begin
         fired_ff[idx_ff[IDX_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         cmd_ff <= tbis_pkg::cmd_type'(req_cmd);
         now_ff <= req_now;
         st_ff  <= req_start_time;
         en_ff  <= req_end_time;
         dur_ff <= req_duration;
         cb_ff  <= req_has_callback;
      end
      if (ctrl.load_rsp) begin
         rsp_buzzer_on       <= new_buzzer;
         rsp_changed         <= stat.is_tick && (on_ff != buzzer_ff);
         rsp_tone_out        <= new_buzzer ? tone_ff : '0;
         rsp_callbacks_fired <= fire_ff;
         rsp_accepted        <= acc_ff;
      end
   end

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      on_in        = on_ff;
      fire_in      = fire_ff;
      acc_in       = acc_ff;
      buzzer_in    = buzzer_ff;
      tone_in      = csr_wr_en ? csr_wr_data : tone_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (ctrl.capture) begin
         idx_in  = '0;
         step_in = '0;
         on_in   = 1'b0;
         fire_in = '0;
         acc_in  = '0;
      end
      if (ctrl.scan_step) begin
         idx_in = idx_ff + CNT_W'(1);
         if (active) on_in = 1'b1;
         if (fire_now) fire_in = fire_ff + FIRE_W'(1);
      end
      // The last entry takes the expired slot, which is then checked again.
      if (ctrl.move) count_in = last_cnt;
      if (ctrl.insert) begin
         step_in = step_ff + STEP_W'(1);
         if (do_insert) begin
            count_in = count_ff + CNT_W'(1);
            acc_in   = acc_ff + ACC_W'(1);
         end
      end
      if (ctrl.load_rsp) begin
         buzzer_in    = new_buzzer;
         rsp_valid_in = 1'b1;
         if (stat.is_clear) count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         step_ff      <= '0;
         on_ff        <= 1'b0;
         fire_ff      <= '0;
         acc_ff       <= '0;
         buzzer_ff    <= 1'b0;
         tone_ff      <= tbis_pkg::TONE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         step_ff      <= step_in;
         on_ff        <= on_in;
         fire_ff      <= fire_in;
         acc_ff       <= acc_in;
         buzzer_ff    <= buzzer_in;
         tone_ff      <= tone_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count exceeds table size");

   assert property (@(posedge clock) disable iff (reset)
      ctrl.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      (ctrl.load_rsp && stat.is_clear) |=> (count_ff == '0))
      else $error("clear left entries in the table");

   assert property (@(posedge clock) disable iff (reset)
      ctrl.move |-> (count_ff != '0) && (idx_ff < count_ff))
      else $error("entry move with no valid source");

   assert property (@(posedge clock) disable iff (reset)
      ctrl.scan_step |-> (fire_ff <= FIRE_W'(MAX_ENTRIES)))
      else $error("callback count exceeds table size");

endmodule

[hdl/timed_beep_interval_scheduler_core.sv]
// Top level of the timed beep interval scheduler.
//
//  Port group   Direction  Handshake      Carries
//  req_chan     in         valid/ready    cmd, now, start_time, end_time, duration, has_callback
//  rsp_chan     out        valid/ready    buzzer_on, changed, tone_out, callbacks_fired, accepted
//  csr_*        in         write enable   tone_hz
//
// Items are processed one at a time by a walk over the entry table, which has one read port.
// A tick scans each surviving entry once and moves the last entry into each expired slot.
// Schedule and beep insert one entry, two-entry patterns two, countdown three; clear inserts none.
// A finished result waits in the output register; a new item is taken meanwhile.
// Reset is synchronous; it empties the table, turns the buzzer off and sets the tone to 800.
module timed_beep_interval_scheduler_core (
   input  logic                        clock,
   input  logic                        reset,
   tbis_req_if.sink                    req_chan,
   tbis_rsp_if.source                  rsp_chan,
   input  logic                        csr_wr_en,
   input  logic [tbis_pkg::TONE_W-1:0] csr_wr_data
);

   tbis_pkg::ctrl_type ctrl;
   tbis_pkg::stat_type stat;

   tbis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   tbis_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctrl                (ctrl),
      .stat                (stat),
      .req_cmd             (req_chan.cmd),
      .req_now             (req_chan.now),
      .req_start_time      (req_chan.start_time),
      .req_end_time        (req_chan.end_time),
      .req_duration        (req_chan.duration),
      .req_has_callback    (req_chan.has_callback),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_buzzer_on       (rsp_chan.buzzer_on),
      .rsp_changed         (rsp_chan.changed),
      .rsp_tone_out        (rsp_chan.tone_out),
      .rsp_callbacks_fired (rsp_chan.callbacks_fired),
      .rsp_accepted        (rsp_chan.accepted)
   );

endmodule

[sim/tb.sv]
// Self-checking testbench for the timed beep interval scheduler core.
`timescale 1ns / 100ps

module tb;

   localparam int CLK_HALF      = 6;
   localparam int RESET_CYCLES  = 6;
   localparam int PHASE_ITEMS   = 190;
   localparam int NUM_PHASES    = 5;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      tbis_pkg::cmd_type                 cmd;
      logic [tbis_pkg::TIME_W-1:0]       now;
      logic [tbis_pkg::TIME_W-1:0]       start_time;
      logic [tbis_pkg::TIME_W-1:0]       end_time;
      logic [tbis_pkg::DUR_W-1:0]        duration;
      logic                              has_callback;
   } beep_cmd_type;

   typedef struct packed {
      logic                              buzzer_on;
      logic                              changed;
      logic [tbis_pkg::TONE_W-1:0]       tone_out;
      logic [tbis_pkg::FIRE_W-1:0]       callbacks_fired;
      logic [tbis_pkg::ACC_W-1:0]        accepted;
   } buzzer_rsp_type;

   typedef struct {
      beep_cmd_type   item;
      bit             typed;
      buzzer_rsp_type rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [tbis_pkg::TONE_W-1:0] csr_wr_data;

   tbis_req_if req_chan ();
   tbis_rsp_if rsp_chan ();

   timed_beep_interval_scheduler_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #CLK_HALF clock = ~clock;

   // Shadow copy of the interval table, buzzer and tone register.
   logic [tbis_pkg::TIME_W-1:0] slot_start [tbis_pkg::MAX_ENTRIES];
   logic [tbis_pkg::TIME_W-1:0] slot_end   [tbis_pkg::MAX_ENTRIES];
   logic                        slot_sig   [tbis_pkg::MAX_ENTRIES];
   logic                        slot_fired [tbis_pkg::MAX_ENTRIES];
   int                          slot_count = 0;
   logic                        buzzer_mdl = 1'b0;
   logic [tbis_pkg::TONE_W-1:0] tone_mdl   = tbis_pkg::TONE_RESET;
   logic [tbis_pkg::TIME_W-1:0] ms_base    = '0;

   buzzer_rsp_type pending_rsp [$];
   dir_row_type    dir_tab [$];

   int mismatches      = 0;
   int items_sent      = 0;
   int results_checked = 0;
   int firing_ticks    = 0;
   int refused_inserts = 0;
   int cycle_count     = 0;
   int send_idle_pct   = 0;
   int recv_stall_pct  = 0;
   int hold_asked      = 0;
   int hold_served     = 0;
   int hold_left       = 0;

   function automatic logic [tbis_pkg::ACC_W-1:0] add_slot(
         logic [tbis_pkg::TIME_W-1:0] s, logic [tbis_pkg::TIME_W-1:0] e, logic sig);
      if (slot_count >= tbis_pkg::MAX_ENTRIES) begin
         refused_inserts++;
         return '0;
      end
      slot_start[slot_count] = s;
      slot_end[slot_count]   = e;
      slot_sig[slot_count]   = sig;
      slot_fired[slot_count] = 1'b0;
      slot_count++;
      return tbis_pkg::ACC_W'(1);
   endfunction

   function automatic buzzer_rsp_type predict_buzzer(beep_cmd_type it);
      buzzer_rsp_type              r;
      logic                        on;
      int                          i;
      logic [tbis_pkg::TIME_W-1:0] t;
      r  = '0;
      on = 1'b0;
      t  = it.now;
      case (it.cmd)
         tbis_pkg::CMD_TICK: begin
            // An expired slot takes the last slot's place and the walk restarts.
            i = 0;
            while (i < slot_count) begin
               if (slot_end[i] < t) begin
                  slot_count--;
                  slot_start[i] = slot_start[slot_count];
                  slot_end[i]   = slot_end[slot_count];
                  slot_sig[i]   = slot_sig[slot_count];
                  slot_fired[i] = slot_fired[slot_count];
                  i = 0;
               end else begin
                  i++;
               end
            end
            for (i = 0; i < slot_count; i++) begin
               if (slot_start[i] <= t && t <= slot_end[i]) begin
                  on = 1'b1;
                  if (slot_sig[i] && !slot_fired[i]) begin
                     slot_fired[i]     = 1'b1;
                     r.callbacks_fired = r.callbacks_fired + 1'b1;
                  end
               end
            end
            if (on != buzzer_mdl) begin
               r.changed  = 1'b1;
               buzzer_mdl = on;
            end
         end
         tbis_pkg::CMD_SCHEDULE: begin
            r.accepted = add_slot(it.start_time, it.end_time, it.has_callback);
         end
         tbis_pkg::CMD_BEEP: r.accepted = add_slot(t, t + {1'b0, it.duration}, 1'b0);
         tbis_pkg::CMD_SUCCESS: begin
            r.accepted = add_slot(t, t + 300, 1'b0);
            r.accepted = r.accepted + add_slot(t + 600, t + 900, 1'b0);
         end
         tbis_pkg::CMD_ERROR: begin
            r.accepted = add_slot(t, t + 1000, 1'b0);
            r.accepted = r.accepted + add_slot(t + 1100, t + 1200, 1'b0);
         end
         tbis_pkg::CMD_WARNING: begin
            r.accepted = add_slot(t, t + 400, 1'b0);
            r.accepted = r.accepted + add_slot(t + 800, t + 1200, 1'b0);
         end
         tbis_pkg::CMD_COUNTDOWN: begin
            r.accepted = add_slot(t, t + 1000, 1'b0);
            r.accepted = r.accepted + add_slot(t + 2000, t + 3000, 1'b0);
            r.accepted = r.accepted + add_slot(t + 4000, t + 6000, it.has_callback);
         end
         default: begin
            buzzer_mdl = 1'b0;
            slot_count = 0;
         end
      endcase
      r.buzzer_on = buzzer_mdl;
      r.tone_out  = buzzer_mdl ? tone_mdl : '0;
      return r;
   endfunction

   function automatic buzzer_rsp_type rsp_of(logic on, logic chg,
                                             logic [tbis_pkg::TONE_W-1:0] tone,
                                             logic [tbis_pkg::FIRE_W-1:0] fired,
                                             logic [tbis_pkg::ACC_W-1:0] acc);
      buzzer_rsp_type r;
      r.buzzer_on       = on;
      r.changed         = chg;
      r.tone_out        = tone;
      r.callbacks_fired = fired;
      r.accepted        = acc;
      return r;
   endfunction

   function automatic dir_row_type drow(tbis_pkg::cmd_type c,
                                        logic [tbis_pkg::TIME_W-1:0] t,
                                        logic [tbis_pkg::TIME_W-1:0] s,
                                        logic [tbis_pkg::TIME_W-1:0] e,
                                        logic [tbis_pkg::DUR_W-1:0] d, logic cb,
                                        bit typed, buzzer_rsp_type r);
      dir_row_type row;
      row.item.cmd          = c;
      row.item.now          = t;
      row.item.start_time   = s;
      row.item.end_time     = e;
      row.item.duration     = d;
      row.item.has_callback = cb;
      row.typed             = typed;
      row.rsp               = r;
      return row;
   endfunction

   // Mostly a plausible timeline of ticks and inserts around a moving time base,
   // with some items carrying arbitrary values in every field.
   function automatic beep_cmd_type random_item();
      beep_cmd_type it;
      int           pick;
      it.cmd          = tbis_pkg::cmd_type'($urandom_range(7));
      it.now          = $urandom;
      it.start_time   = $urandom;
      it.end_time     = $urandom;
      it.duration     = tbis_pkg::DUR_W'($urandom);
      it.has_callback = 1'($urandom_range(1));
      if ($urandom_range(99) >= 10) begin
         if ($urandom_range(99) < 3) begin
            ms_base = $urandom_range(1) ? $urandom : 32'hFFFF_FC00 + $urandom_range(1023);
         end
         pick = $urandom_range(99);
         it.now = ms_base;
         if (pick < 50) begin
            it.cmd  = tbis_pkg::CMD_TICK;
            ms_base = ms_base + $urandom_range(300);
            it.now  = ms_base;
         end else if (pick < 68) begin
            it.cmd        = tbis_pkg::CMD_SCHEDULE;
            it.start_time = ms_base + $urandom_range(500);
            it.end_time   = it.start_time + $urandom_range(800);
         end else if (pick < 78) begin
            it.cmd      = tbis_pkg::CMD_BEEP;
            it.duration = tbis_pkg::DUR_W'($urandom_range(1500));
         end else if (pick < 97) begin
            it.cmd = tbis_pkg::cmd_type'($urandom_range(int'(tbis_pkg::CMD_COUNTDOWN),
                                                        int'(tbis_pkg::CMD_SUCCESS)));
         end else begin
            it.cmd = tbis_pkg::CMD_CLEAR;
         end
      end
      return it;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic offer_item(input beep_cmd_type it, input bit typed,
                             input buzzer_rsp_type typed_rsp);
      int             gap;
      buzzer_rsp_type r;
      gap = 0;
      while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.cmd          <= it.cmd;
      req_chan.now          <= it.now;
      req_chan.start_time   <= it.start_time;
      req_chan.end_time     <= it.end_time;
      req_chan.duration     <= it.duration;
      req_chan.has_callback <= it.has_callback;
      do @(posedge clock); while (!req_chan.ready);
      r = predict_buzzer(it);
      if (r.callbacks_fired != 0) firing_ticks++;
      pending_rsp.push_back(typed ? typed_rsp : r);
      items_sent++;
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_tone(input logic [tbis_pkg::TONE_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tone_mdl = v;
   endtask

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_rsp.size());
         $display("timed_beep_interval_scheduler_core: mismatch");
         $finish;
      end
   end

   // Result sink: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served    <= hold_asked;
         hold_left      <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left      <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      buzzer_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t ns: result with no item outstanding", $time);
            mismatches++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("buzzer_on", want.buzzer_on, rsp_chan.buzzer_on);
            check_field("changed", want.changed, rsp_chan.changed);
            check_field("tone_out", want.tone_out, rsp_chan.tone_out);
            check_field("callbacks_fired", want.callbacks_fired, rsp_chan.callbacks_fired);
            check_field("accepted", want.accepted, rsp_chan.accepted);
            results_checked++;
         end
      end
   end

   initial begin
      int          send_tab [NUM_PHASES];
      int          stall_tab [NUM_PHASES];
      logic [15:0] tone_tab [NUM_PHASES];
      int          ph;
      int          n;

      req_chan.valid        = 1'b0;
      req_chan.cmd          = tbis_pkg::CMD_TICK;
      req_chan.now          = '0;
      req_chan.start_time   = '0;
      req_chan.end_time     = '0;
      req_chan.duration     = '0;
      req_chan.has_callback = 1'b0;
      rsp_chan.ready        = 1'b0;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;

      send_tab  = '{0, 48, 0, 32, 0};
      stall_tab = '{0, 0, 48, 32, 0};
      tone_tab  = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h0001, 16'($urandom)};

      // Directed sequence: extremes, wrap of the time sums, a full table,
      // callbacks that fire only once, expiry and clear.
      dir_tab.push_back(drow(tbis_pkg::CMD_TICK, 0, 0, 0, 0, 0, 1, rsp_of(0, 0, 0, 0, 0)));
      dir_tab.push_back(drow(tbis_pkg::CMD_SCHEDULE, 0, 0, 32'hFFFF_FFFF, 0, 1, 1,
                             rsp_of(0, 0, 0, 0, 1)));
      dir_tab.push_back(drow(tbis_pkg::CMD_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 1,
                             rsp_of(1, 1, tbis_pkg::TONE_RESET, 1, 0)));
      dir_tab.push_back(drow(tbis_pkg::CMD_TICK, 32'hFFFF_FFFF, 0, 0, 0, 0, 1,
                             rsp_of(1, 0, tbis_pkg::TONE_RESET, 0, 0)));
      dir_tab.push_back(drow(tbis_pkg::CMD_BEEP, 32'hFFFF_FFFF, 0, 0, 31'h7FFF_FFFF, 0, 1,
                             rsp_of(1, 0, tbis_pkg::TONE_RESET, 0, 1)));
      dir_tab.push_back(drow(tbis_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0, '0));
      dir_tab.push_back(drow(tbis_pkg::CMD_SUCCESS, 100, 0, 0, 0, 0, 0, '0));
      dir_tab.push_back(drow(tbis_pkg::CMD_ERROR, 5000, 0, 0, 0, 0, 0, '0));
      dir_tab.push_back(drow(tbis_pkg::CMD_WARNING, 9000, 0, 0, 0, 0, 0, '0));
      dir_tab.push_back(drow(tbis_pkg::CMD_COUNTDOWN, 0, 0, 0, 0, 1, 1,
                             rsp_of(1, 0, tbis_pkg::TONE_RESET, 0, 0)));
      dir_tab.push_back(drow(tbis_pkg::CMD_TICK, 1000, 0, 0, 0, 0, 0, '0));
      dir_tab.push_back(drow(tbis_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 1, rsp_of(0, 0, 0, 0, 0)));
      dir_tab.push_back(drow(tbis_pkg::CMD_COUNTDOWN, 0, 0, 0, 0, 1, 1,
                             rsp_of(0, 0, 0, 0, 3)));
      dir_tab.push_back(drow(tbis_pkg::CMD_TICK, 4000, 0, 0, 0, 0, 1,
                             rsp_of(1, 1, tbis_pkg::TONE_RESET, 1, 0)));
      dir_tab.push_back(drow(tbis_pkg::CMD_TICK, 7000, 0, 0, 0, 0, 1,
                             rsp_of(0, 1, 0, 0, 0)));
      dir_tab.push_back(drow(tbis_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 1, rsp_of(0, 0, 0, 0, 0)));
      for (n = 0; n < 6; n++) begin
         dir_tab.push_back(drow(tbis_pkg::CMD_SCHEDULE, 0, 10, 20, 0, 1, 1,
                                rsp_of(0, 0, 0, 0, 1)));
      end
      // Only two of the three countdown slots fit in the table.
      dir_tab.push_back(drow(tbis_pkg::CMD_COUNTDOWN, 10, 0, 0, 0, 1, 1,
                             rsp_of(0, 0, 0, 0, 2)));
      dir_tab.push_back(drow(tbis_pkg::CMD_TICK, 15, 0, 0, 0, 0, 1,
                             rsp_of(1, 1, tbis_pkg::TONE_RESET, 6, 0)));
      dir_tab.push_back(drow(tbis_pkg::CMD_TICK, 3000, 0, 0, 0, 0, 0, '0));

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[k]) begin
         offer_item(dir_tab[k].item, dir_tab[k].typed, dir_tab[k].rsp);
      end
      drain();

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         write_tone(tone_tab[ph]);
         send_idle_pct  = send_tab[ph];
         recv_stall_pct = stall_tab[ph];
         // The last phase holds the result side off so the core backs up.
         if (ph == NUM_PHASES - 1) hold_asked <= hold_asked + 1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            offer_item(random_item(), 1'b0, '0);
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d items through %0d tone settings; %0d results checked.",
               items_sent, NUM_PHASES + 1, results_checked);
      $display("Ticks that fired callbacks: %0d; inserts refused on a full table: %0d.",
               firing_ticks, refused_inserts);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("timed_beep_interval_scheduler_core: match");
      end else begin
         $display("timed_beep_interval_scheduler_core: mismatch");
      end
      $finish;
   end

endmodule
